// ----- hdl/bsws_pkg.sv -----
package bsws_pkg;

  localparam int DEPTH = 8;
  localparam int DW = 32;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    FN_PUSH = 3'd0,
    FN_POP  = 3'd1,
    FN_PEEK = 3'd2,
    FN_DISP = 3'd3,
    FN_SORT = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ONE,
    S_ERR,
    S_LIST_RD,
    S_LIST_EMIT,
    S_SORT_POP,
    S_SORT_CMP,
    S_SORT_MOVE,
    S_DRAIN,
    S_DRAIN_MOVE
  } state_t;

  typedef struct packed {
    logic    st_push;      // main stack gets the input word at the fill level
    logic    st_rd_top;    // read the top of the main stack
    logic    fill_dec;     // drop the top of the main stack
    logic    st_rd_idx;    // read the main stack at the list index
    logic    idx_load;     // list index starts at the fill level
    logic    idx_dec;
    logic    sc_rd;        // read the top of the scratch stack
    logic    sc_push_held; // scratch stack gets the held word
    logic    st_push_sc;   // move the scratch top onto the main stack
    logic    out_load;
    status_t out_status;
    logic    out_last;
  } cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic fill_full;
    logic aux_zero;
    logic idx_one;
    logic less;
    logic out_free;
  } stat_t;

endpackage

// ----- hdl/bsws_ram.sv -----
module bsws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/bsws_dp.sv -----
module bsws_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bsws_pkg::cmd_t                  cmd,
  output bsws_pkg::stat_t                 stat,
  input  logic signed [bsws_pkg::DW-1:0]  in_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [bsws_pkg::DW-1:0]  out_data,
  output logic [1:0]                      out_status,
  output logic                            out_last
);

  logic [bsws_pkg::CW-1:0] fill_r, fill_nxt;
  logic [bsws_pkg::CW-1:0] aux_r, aux_nxt;
  logic [bsws_pkg::CW-1:0] idx_r, idx_nxt;
  logic [bsws_pkg::CW-1:0] fill_m1, aux_m1, idx_m1;

  logic                    st_wr_en;
  logic [bsws_pkg::AW-1:0] st_rd_addr;
  logic [bsws_pkg::DW-1:0] st_wr_data, st_rd_data, sc_rd_data;

  logic                    out_valid_r, out_valid_nxt;
  logic [bsws_pkg::DW-1:0] out_data_r, out_data_nxt;
  logic [1:0]              out_status_r, out_status_nxt;
  logic                    out_last_r, out_last_nxt;

  assign fill_m1 = fill_r - bsws_pkg::CW'(1);
  assign aux_m1  = aux_r - bsws_pkg::CW'(1);
  assign idx_m1  = idx_r - bsws_pkg::CW'(1);

  assign st_wr_en   = cmd.st_push | cmd.st_push_sc;
  assign st_wr_data = cmd.st_push ? in_value : sc_rd_data;
  assign st_rd_addr = cmd.st_rd_idx ? idx_m1[bsws_pkg::AW-1:0] : fill_m1[bsws_pkg::AW-1:0];

  bsws_ram #(.WIDTH(bsws_pkg::DW), .DEPTH(bsws_pkg::DEPTH)) u_stack_ram (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (fill_r[bsws_pkg::AW-1:0]),
    .wr_data (st_wr_data),
    .rd_en   (cmd.st_rd_top | cmd.st_rd_idx),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  // The word taken off the main stack during the sort stays in the read register.
  bsws_ram #(.WIDTH(bsws_pkg::DW), .DEPTH(bsws_pkg::DEPTH)) u_scratch_ram (
    .clk     (clk),
    .wr_en   (cmd.sc_push_held),
    .wr_addr (aux_r[bsws_pkg::AW-1:0]),
    .wr_data (st_rd_data),
    .rd_en   (cmd.sc_rd),
    .rd_addr (aux_m1[bsws_pkg::AW-1:0]),
    .rd_data (sc_rd_data)
  );

  always_comb begin
    fill_nxt = fill_r;
    if (st_wr_en) begin
      fill_nxt = fill_r + bsws_pkg::CW'(1);
    end else if (cmd.fill_dec) begin
      fill_nxt = fill_m1;
    end
    aux_nxt = aux_r;
    if (cmd.sc_push_held) begin
      aux_nxt = aux_r + bsws_pkg::CW'(1);
    end else if (cmd.st_push_sc) begin
      aux_nxt = aux_m1;
    end
    idx_nxt = idx_r;
    if (cmd.idx_load) begin
      idx_nxt = fill_r;
    end else if (cmd.idx_dec) begin
      idx_nxt = idx_m1;
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    if (cmd.out_load) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = (cmd.out_status == bsws_pkg::ST_OK) ? st_rd_data : '0;
      out_status_nxt = cmd.out_status;
      out_last_nxt   = cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      aux_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      aux_r       <= aux_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign stat.fill_zero = (fill_r == '0);
  assign stat.fill_full = (fill_r == bsws_pkg::CW'(bsws_pkg::DEPTH));
  assign stat.aux_zero  = (aux_r == '0);
  assign stat.idx_one   = (idx_r == bsws_pkg::CW'(1));
  assign stat.less      = ($signed(st_rd_data) < $signed(sc_rd_data));
  assign stat.out_free  = ~out_valid_r | out_ready;

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

// ----- hdl/bsws_ctrl.sv -----
module bsws_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            in_func,
  input  bsws_pkg::stat_t       stat,
  output bsws_pkg::cmd_t        cmd
);

  bsws_pkg::state_t  state_r, state_nxt;
  bsws_pkg::status_t err_r, err_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsws_pkg::S_IDLE;
      err_r   <= bsws_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      err_r   <= err_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    err_nxt   = err_r;
    cmd       = '0;
    cmd.out_status = bsws_pkg::ST_OK;
    in_ready  = 1'b0;
    case (state_r)
      bsws_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_func)
            bsws_pkg::FN_PUSH: begin
              if (stat.fill_full) begin
                err_nxt   = bsws_pkg::ST_FULL;
                state_nxt = bsws_pkg::S_ERR;
              end else begin
                cmd.st_push = 1'b1;
              end
            end
            bsws_pkg::FN_POP, bsws_pkg::FN_PEEK: begin
              if (stat.fill_zero) begin
                err_nxt   = bsws_pkg::ST_EMPTY;
                state_nxt = bsws_pkg::S_ERR;
              end else begin
                cmd.st_rd_top = 1'b1;
                cmd.fill_dec  = (in_func == bsws_pkg::FN_POP);
                state_nxt     = bsws_pkg::S_ONE;
              end
            end
            bsws_pkg::FN_DISP: begin
              if (stat.fill_zero) begin
                err_nxt   = bsws_pkg::ST_EMPTY;
                state_nxt = bsws_pkg::S_ERR;
              end else begin
                cmd.idx_load = 1'b1;
                state_nxt    = bsws_pkg::S_LIST_RD;
              end
            end
            bsws_pkg::FN_SORT: begin
              state_nxt = bsws_pkg::S_SORT_POP;
            end
            default: begin
            end
          endcase
        end
      end
      bsws_pkg::S_ONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          state_nxt    = bsws_pkg::S_IDLE;
        end
      end
      bsws_pkg::S_ERR: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = err_r;
          cmd.out_last   = 1'b1;
          state_nxt      = bsws_pkg::S_IDLE;
        end
      end
      bsws_pkg::S_LIST_RD: begin
        cmd.st_rd_idx = 1'b1;
        state_nxt     = bsws_pkg::S_LIST_EMIT;
      end
      bsws_pkg::S_LIST_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = stat.idx_one;
          cmd.idx_dec  = 1'b1;
          state_nxt    = stat.idx_one ? bsws_pkg::S_IDLE : bsws_pkg::S_LIST_RD;
        end
      end
      // Take the top word off the main stack and hold it in the read register.
      bsws_pkg::S_SORT_POP: begin
        if (stat.fill_zero) begin
          state_nxt = bsws_pkg::S_DRAIN;
        end else begin
          cmd.st_rd_top = 1'b1;
          cmd.fill_dec  = 1'b1;
          state_nxt     = bsws_pkg::S_SORT_CMP;
        end
      end
      bsws_pkg::S_SORT_CMP: begin
        if (stat.aux_zero) begin
          cmd.sc_push_held = 1'b1;
          state_nxt        = bsws_pkg::S_SORT_POP;
        end else begin
          cmd.sc_rd = 1'b1;
          state_nxt = bsws_pkg::S_SORT_MOVE;
        end
      end
      // Larger scratch words go back to the main stack until the held word fits.
      bsws_pkg::S_SORT_MOVE: begin
        if (stat.less) begin
          cmd.st_push_sc = 1'b1;
          state_nxt      = bsws_pkg::S_SORT_CMP;
        end else begin
          cmd.sc_push_held = 1'b1;
          state_nxt        = bsws_pkg::S_SORT_POP;
        end
      end
      bsws_pkg::S_DRAIN: begin
        if (!stat.aux_zero) begin
          cmd.sc_rd = 1'b1;
          state_nxt = bsws_pkg::S_DRAIN_MOVE;
        end else if (stat.fill_zero) begin
          err_nxt   = bsws_pkg::ST_EMPTY;
          state_nxt = bsws_pkg::S_ERR;
        end else begin
          cmd.idx_load = 1'b1;
          state_nxt    = bsws_pkg::S_LIST_RD;
        end
      end
      bsws_pkg::S_DRAIN_MOVE: begin
        cmd.st_push_sc = 1'b1;
        state_nxt      = bsws_pkg::S_DRAIN;
      end
      default: begin
        state_nxt = bsws_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/bounded_stack_with_sort_core.sv -----
// Push writes the input word and gives no item unless the stack is full.
// Pop and peek give their item once the output register is free; errors likewise.
// Display lists n entries; sort reorders the stack via the scratch store before the listing.
// One input item is worked on at a time; rst_n is synchronous, active low, and empties the stack.
module bounded_stack_with_sort_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     in_func,
  input  logic signed [bsws_pkg::DW-1:0] in_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [bsws_pkg::DW-1:0] out_data,
  output logic [1:0]                     out_status,
  output logic                           out_last
);

  bsws_pkg::cmd_t  cmd;
  bsws_pkg::stat_t stat;

  bsws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_func  (in_func),
    .stat     (stat),
    .cmd      (cmd)
  );

  bsws_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .out_status (out_status),
    .out_last   (out_last)
  );

endmodule

// ----- hdl/bsws_checker.sv -----
module bsws_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [bsws_pkg::DW-1:0] out_data,
  input logic [1:0]                     out_status,
  input logic                           out_last
);

  // A stalled result item holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data) && $stable(out_status)
      && $stable(out_last))
    else $error("result item changed while stalled");

  // Error items carry zero data and close their input's results.
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != bsws_pkg::ST_OK |-> out_data == '0 && out_last)
    else $error("error item malformed");

  // Only the three defined status codes ever appear on a result item.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == bsws_pkg::ST_OK || out_status == bsws_pkg::ST_EMPTY
      || out_status == bsws_pkg::ST_FULL)
    else $error("unknown status code");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item presented straight after reset");

endmodule

bind bounded_stack_with_sort_core bsws_checker u_bsws_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_data   (out_data),
  .out_status (out_status),
  .out_last   (out_last)
);
